// ===== design/dfme_pkg.sv =====
`default_nettype none

package dfme_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PPF_W    = 14;
	localparam int DECAY_W  = 16;
	localparam int AVG_W    = 16;
	localparam int SUM_W    = 29;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [SUM_W-1:0]    SUM_MAX    = 29'h1FFF_FFFF;
	localparam logic [AVG_W-1:0]    FULL_SCALE = 16'hFFFF;
	localparam logic [DECAY_W:0]    Q16_ONE    = 17'h1_0000;
	localparam logic [15:0]         ROUND_HALF = 16'h8000;

	localparam logic [PPF_W-1:0]   PPF_RESET   = 14'd8192;
	localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd58982;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXELS_PER_FRAME = 1'b0,
		REG_DECAY_FACTOR     = 1'b1
	} cfg_reg_e;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== design/dfme_stream_if.sv =====
`default_nettype none

interface dfme_in_if;
	logic                          valid;
	logic                          ready;
	logic [dfme_pkg::SAMPLE_W-1:0] depth_sample;

	modport source (output valid, output depth_sample, input ready);
	modport sink   (input valid, input depth_sample, output ready);
endinterface

interface dfme_out_if;
	logic                       valid;
	logic                       ready;
	logic [dfme_pkg::AVG_W-1:0] movement_average;
	logic [dfme_pkg::SUM_W-1:0] frame_change_sum;

	modport source (output valid, output movement_average, output frame_change_sum, input ready);
	modport sink   (input valid, input movement_average, input frame_change_sum, output ready);
endinterface

`default_nettype wire

// ===== design/dfme_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module dfme_div #(
	parameter int NUM_W = 45,
	parameter int DEN_W = 30
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [NUM_W-1:0]   num,
	input  wire logic [DEN_W-1:0]   den,
	output logic      [NUM_W-1:0]   quot,
	output dfme_pkg::div_stat_t     stat
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] shift_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, shift_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits leave at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= num;
			rem_q   <= '0;
			den_q   <= den;
		end else if (busy_q) begin
			shift_q <= {shift_q[NUM_W-2:0], fits};
			rem_q   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign quot      = shift_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ===== design/depth_frame_motion_energy.sv =====
// After a pixel is taken, its history row is read and written back, then scanned one
//   slot per cycle and its change accumulated, before the next pixel can be taken.
// The last pixel of a frame adds a bit-serial divide and a multiply and mix; its result
//   then waits in the output register while the next frame's pixels go on.
// Reset clears position, ring slot, sum, average and the primed flag; the history memory
//   is not cleared, the first frame after reset writes every slot of each pixel.
`default_nettype none

module depth_frame_motion_energy #(
	parameter int HISTORY_FRAMES = 8,
	parameter int RECENT_FRAMES  = 3,
	parameter int MAX_PIXELS     = 8192
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	dfme_in_if.sink                               pixel,
	dfme_out_if.source                            result,
	input  wire logic                             cfg_wr_en,
	input  wire logic [dfme_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dfme_pkg::CFG_W-1:0]       cfg_data
);

	localparam int SW    = dfme_pkg::SAMPLE_W;
	localparam int SLOT_W = $clog2(HISTORY_FRAMES);
	localparam int POS_W = $clog2(MAX_PIXELS);
	localparam int NW    = $clog2(MAX_PIXELS + 1);
	localparam int EXT_W = (NW > dfme_pkg::PPF_W) ? NW : dfme_pkg::PPF_W;
	localparam int DEN_W = NW + 16;
	localparam int NUM_W = dfme_pkg::SUM_W + 16;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_ACCUM = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	logic [dfme_pkg::PPF_W-1:0]   ppf_q;
	logic [dfme_pkg::DECAY_W-1:0] decay_q;

	logic [POS_W-1:0]             pos_q;
	logic [SLOT_W-1:0]            newest_q;
	logic                         primed_q;
	logic [dfme_pkg::SUM_W-1:0]   acc_q;
	logic [dfme_pkg::AVG_W-1:0]   avg_q;
	logic [NW-1:0]                n_q;
	logic [SW-1:0]                sample_q;

	logic [HISTORY_FRAMES-1:0][SW-1:0] hist_mem [MAX_PIXELS];
	logic [HISTORY_FRAMES-1:0][SW-1:0] rd_row_q;
	logic [HISTORY_FRAMES-1:0][SW-1:0] scan_row_q;
	logic [HISTORY_FRAMES-1:0][SW-1:0] new_row;

	logic [SLOT_W-1:0]            age_q;
	logic [SLOT_W-1:0]            slot_idx_q;
	logic [SW-1:0]                recent_q;
	logic [SW-1:0]                ref_q;

	logic [dfme_pkg::SUM_W-1:0]   sum_q;
	logic [31:0]                  keep_prod_q;
	logic [32:0]                  new_prod_q;

	logic                         out_valid_q;
	logic [dfme_pkg::AVG_W-1:0]   out_avg_q;
	logic [dfme_pkg::SUM_W-1:0]   out_sum_q;

	logic                         in_take;
	logic                         mem_we;
	logic                         out_load;
	logic [EXT_W-1:0]             n_ext;
	logic [NW-1:0]                n_eff;
	logic [SW-1:0]                scan_val;
	logic [SW-1:0]                diff;
	logic [dfme_pkg::SUM_W:0]     acc_wide;
	logic [dfme_pkg::SUM_W-1:0]   acc_next;
	logic                         frame_end;
	logic [NUM_W-1:0]             div_num;
	logic [DEN_W-1:0]             div_den;
	logic [NUM_W-1:0]             div_quot;
	logic                         div_start;
	dfme_pkg::div_stat_t          div_stat;
	logic [dfme_pkg::AVG_W-1:0]   norm;
	logic [dfme_pkg::DECAY_W:0]   fresh_w;
	logic [33:0]                  mix_full;
	logic [17:0]                  mix_sh;
	logic [dfme_pkg::AVG_W-1:0]   mix;

	// ---------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppf_q   <= dfme_pkg::PPF_RESET;
			decay_q <= dfme_pkg::DECAY_RESET;
		end else if (cfg_wr_en) begin
			unique case (dfme_pkg::cfg_reg_e'(cfg_index))
				dfme_pkg::REG_PIXELS_PER_FRAME: ppf_q   <= cfg_data[dfme_pkg::PPF_W-1:0];
				dfme_pkg::REG_DECAY_FACTOR:     ppf_q   <= ppf_q;
				default:                        ppf_q   <= ppf_q;
			endcase
			if (dfme_pkg::cfg_reg_e'(cfg_index) == dfme_pkg::REG_DECAY_FACTOR) begin
				decay_q <= cfg_data;
			end
		end
	end

	// pixel count with zero taken as one and clamped to the memory depth
	always_comb begin
		n_ext = EXT_W'(ppf_q);
		if (n_ext == '0) begin
			n_eff = NW'(1);
		end else if (n_ext > EXT_W'(MAX_PIXELS)) begin
			n_eff = NW'(MAX_PIXELS);
		end else begin
			n_eff = n_ext[NW-1:0];
		end
	end

	// ---------------- handshake
	assign pixel.ready = (state_q == ST_IDLE);
	assign in_take     = pixel.valid && (state_q == ST_IDLE);
	assign mem_we      = (state_q == ST_READ);
	assign out_load    = (state_q == ST_OUT) && (!out_valid_q || result.ready);

	// ---------------- history memory, one row of all slots per pixel
	always_comb begin
		for (int j = 0; j < HISTORY_FRAMES; j++) begin
			if (!primed_q || SLOT_W'(j) == newest_q) begin
				new_row[j] = sample_q;
			end else begin
				new_row[j] = rd_row_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[pos_q] <= new_row;
		end
		if (in_take) begin
			rd_row_q <= hist_mem[pos_q];
		end
	end

	// ---------------- datapath
	assign scan_val = scan_row_q[slot_idx_q];
	assign diff     = (recent_q > ref_q) ? (recent_q - ref_q) : '0;
	assign acc_wide = {1'b0, acc_q} + (dfme_pkg::SUM_W + 1)'(diff);
	assign acc_next = acc_wide[dfme_pkg::SUM_W] ? dfme_pkg::SUM_MAX : acc_wide[dfme_pkg::SUM_W-1:0];
	assign frame_end = !((NW'(pos_q) + NW'(1)) < n_q);

	assign div_start = (state_q == ST_ACCUM) && frame_end;
	assign div_num   = {acc_next, 16'h0000};
	assign div_den   = (DEN_W'(n_q) << 16) - DEN_W'(n_q);

	dfme_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	assign norm    = (|div_quot[NUM_W-1:16]) ? dfme_pkg::FULL_SCALE : div_quot[15:0];
	assign fresh_w = dfme_pkg::Q16_ONE - {1'b0, decay_q};

	always_comb begin
		mix_full = 34'(keep_prod_q) + 34'(new_prod_q) + 34'(dfme_pkg::ROUND_HALF);
		mix_sh   = mix_full[33:16];
		mix      = (|mix_sh[17:16]) ? dfme_pkg::FULL_SCALE : mix_sh[15:0];
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= pixel.depth_sample;
			n_q      <= n_eff;
		end
		if (state_q == ST_READ) begin
			scan_row_q <= new_row;
			recent_q   <= dfme_pkg::FULL_SCALE;
			ref_q      <= '0;
			age_q      <= '0;
			slot_idx_q <= newest_q;
		end
		if (state_q == ST_SCAN) begin
			if (32'(age_q) < 32'(RECENT_FRAMES)) begin
				if (scan_val < recent_q) recent_q <= scan_val;
			end else begin
				if (scan_val > ref_q) ref_q <= scan_val;
			end
			age_q      <= age_q + 1'b1;
			slot_idx_q <= (slot_idx_q == '0) ? SLOT_W'(HISTORY_FRAMES - 1) : slot_idx_q - 1'b1;
		end
		if (div_start) begin
			sum_q <= acc_next;
		end
		if (state_q == ST_DIV && div_stat.done) begin
			keep_prod_q <= decay_q * avg_q;
			new_prod_q  <= fresh_w * norm;
		end
		if (out_load) begin
			out_avg_q <= mix;
			out_sum_q <= sum_q;
		end
	end

	// ---------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			newest_q    <= '0;
			primed_q    <= 1'b0;
			acc_q       <= '0;
			avg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (age_q == SLOT_W'(HISTORY_FRAMES - 1)) state_q <= ST_ACCUM;
				end
				ST_ACCUM: begin
					if (frame_end) begin
						acc_q    <= '0;
						pos_q    <= '0;
						newest_q <= (newest_q == SLOT_W'(HISTORY_FRAMES - 1)) ?
							'0 : newest_q + 1'b1;
						primed_q <= 1'b1;
						state_q  <= ST_DIV;
					end else begin
						acc_q   <= acc_next;
						pos_q   <= pos_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_stat.done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						avg_q   <= mix;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid            = out_valid_q;
	assign result.movement_average = out_avg_q;
	assign result.frame_change_sum = out_sum_q;

	// ---------------- assertions
	a_take_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == ST_READ)
		else $error("accepted pixel did not start a history read");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < 32'(MAX_PIXELS))
		else $error("pixel position beyond memory depth");

	a_primed_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(primed_q))
		else $error("history primed flag cleared after frame end");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> result.valid)
		else $error("frame result loaded but not presented");

endmodule

`default_nettype wire
